>>> sv/amsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amsa_pkg: shared types and constants of the attribute statistics block
// Holds the request and response payload structs, the command struct of the
// shared divide and square-root unit, operation codes and datapath widths.
// ----------------------------------------------------------------------------

package amsa_pkg;

   // Operation codes carried in the request; every other code is a query.
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;

   // Accumulator widths: Q24.16 sums and Q32.16 sums of squares.
   localparam int SUM_W = 40;
   localparam int SQ_W  = 48;

   // Square of the absolute sum needs 79 bits (at most 2^78).
   localparam int ACC_W = 79;

   // Shared unit: 64-bit operand register, 34-bit partial remainder,
   // 36-bit compare and subtract, 32-bit root.
   localparam int OPND_W = 64;
   localparam int REM_W  = 34;
   localparam int CMP_W  = 36;
   localparam int ROOT_W = 32;
   localparam int STEP_W = 6;
   localparam int CNT_W  = 16;

   // Step counts of the four passes through the shared unit.
   localparam logic [STEP_W-1:0] MEAN_STEPS = 6'd40;
   localparam logic [STEP_W-1:0] TERM_STEPS = 6'd63;
   localparam logic [STEP_W-1:0] VAR_STEPS  = 6'd47;
   localparam logic [STEP_W-1:0] ROOT_STEPS = 6'd32;

   // Saturation limits of the Q8.16 mean and the unsigned Q7.16 deviation.
   localparam logic [23:0] MEAN_MAX = 24'h7F_FFFF;
   localparam logic [23:0] MEAN_MIN = 24'h80_0000;
   localparam logic [22:0] STD_MAX  = 23'h7F_FFFF;

   // One input item.
   typedef struct packed {
      logic [1:0]         op;
      logic [3:0]         attr_index;
      logic signed [23:0] value;
      logic [15:0]        sample_count;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [3:0]         echo_index;
      logic signed [23:0] mean;
      logic [22:0]        std_dev;
   } rsp_type;

   // Command to the shared divide and square-root unit.
   typedef struct packed {
      logic              start;
      logic              is_sqrt;
      logic [STEP_W-1:0] steps;
      logic [CNT_W-1:0]  divisor;
   } unit_cmd_type;

endpackage

>>> sv/amsa_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amsa_unit: shared restoring divider and digit-by-digit square root
// One compare and subtract per cycle. Division takes one dividend bit per
// step from a left-aligned operand, so after N steps the operand register
// holds the quotient. The square root takes two radicand bits per step.
// ----------------------------------------------------------------------------

module amsa_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  amsa_pkg::unit_cmd_type         cmd,
   input  logic [amsa_pkg::OPND_W-1:0]    operand,
   output logic                           done,
   output logic [amsa_pkg::OPND_W-1:0]    result
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [amsa_pkg::STEP_W-1:0]   cnt_ff, cnt_in;
   logic                          sqrt_ff, sqrt_in;
   logic [amsa_pkg::CNT_W-1:0]    dvs_ff, dvs_in;
   logic [amsa_pkg::OPND_W-1:0]   dvd_ff, dvd_in;
   logic [amsa_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [amsa_pkg::ROOT_W-1:0]   root_ff, root_in;

   logic [amsa_pkg::CMP_W-1:0]    r_shift;
   logic [amsa_pkg::CMP_W-1:0]    trial;
   logic [amsa_pkg::CMP_W:0]      diff;
   logic                          ge;

   // Shifted partial remainder and trial value for the current step.
   always_comb begin
      if (sqrt_ff) begin
         r_shift = {rem_ff, dvd_ff[amsa_pkg::OPND_W-1 -: 2]};
         trial   = amsa_pkg::CMP_W'({root_ff, 2'b01});
      end else begin
         r_shift = {1'b0, rem_ff, dvd_ff[amsa_pkg::OPND_W-1]};
         trial   = amsa_pkg::CMP_W'(dvs_ff);
      end
   end

   // The one shared compare and subtract.
   assign diff = {1'b0, r_shift} - {1'b0, trial};
   assign ge   = ~diff[amsa_pkg::CMP_W];

   // Step sequencing.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sqrt_in = sqrt_ff;
      dvs_in  = dvs_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.steps;
         sqrt_in = cmd.is_sqrt;
         dvs_in  = cmd.divisor;
         dvd_in  = operand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == amsa_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         rem_in = ge ? diff[amsa_pkg::REM_W-1:0] : r_shift[amsa_pkg::REM_W-1:0];
         if (sqrt_ff) begin
            dvd_in  = {dvd_ff[amsa_pkg::OPND_W-3:0], 2'b00};
            root_in = {root_ff[amsa_pkg::ROOT_W-2:0], ge};
         end else begin
            dvd_in = {dvd_ff[amsa_pkg::OPND_W-2:0], ge};
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      sqrt_ff <= sqrt_in;
      dvs_ff  <= dvs_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done   = done_ff;
   assign result = sqrt_ff ? amsa_pkg::OPND_W'(root_ff) : dvd_ff;

endmodule

>>> sv/attribute_mean_stddev_accumulator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attribute_mean_stddev_accumulator_top: running mean and deviation per attribute
// Keeps a running sum and sum of squares for each attribute, updates them on
// add or remove, and returns the attribute's mean and sample deviation.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  amsa_pkg::req_type
//   rsp_      out        rsp_valid / rsp_ready  amsa_pkg::rsp_type
//
// One item at a time; req_ready is high only while the sequencer is idle.
// The path to rsp_valid depends on the item: a count of two or more runs all
// four passes of the shared divide and square-root unit, but a variance that
// clamps to zero skips the last two; a count of one runs only the mean pass,
// a count of zero none, and an index out of range goes straight to the result.
// The unit gives one result bit per cycle over 40, 63, 47 and 32 root steps.
// Reset is synchronous; it clears the sequencer, the result valid flag and the
// per-entry valid bits, so every entry reads as zero until first written.
// A stalled result waits in its register; the block idles again after loading it.

module attribute_mean_stddev_accumulator_top #(
   parameter int ATTRIBUTES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  amsa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output amsa_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (ATTRIBUTES > 1) ? $clog2(ATTRIBUTES) : 1;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_READ   = 10'b00_0000_0010,
      ST_UPDATE = 10'b00_0000_0100,
      ST_ABS    = 10'b00_0000_1000,
      ST_MUL    = 10'b00_0001_0000,
      ST_MEAN   = 10'b00_0010_0000,
      ST_TERM   = 10'b00_0100_0000,
      ST_VAR    = 10'b00_1000_0000,
      ST_ROOT   = 10'b01_0000_0000,
      ST_RESULT = 10'b10_0000_0000
   } state_type;

   state_type                    state_ff, state_in;
   logic [1:0]                   op_ff, op_in;
   logic [3:0]                   echo_ff, echo_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [23:0]                  value_ff, value_in;
   logic [23:0]                  abs_v_ff, abs_v_in;
   logic [15:0]                  count_ff, count_in;
   logic [47:0]                  prod_ff, prod_in;
   logic [amsa_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [amsa_pkg::SQ_W-1:0]    sumsq_ff, sumsq_in;
   logic [amsa_pkg::SUM_W-1:0]   abs_sum_ff, abs_sum_in;
   logic [amsa_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [1:0]                   mcnt_ff, mcnt_in;
   logic                         launched_ff, launched_in;
   logic [46:0]                  work_ff, work_in;
   logic [23:0]                  mean_ff, mean_in;
   logic [22:0]                  std_ff, std_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   amsa_pkg::rsp_type            rsp_ff, rsp_in;

   // Attribute stores, the valid bit of each entry and registered read data.
   logic [amsa_pkg::SUM_W-1:0]   sum_mem [ATTRIBUTES];
   logic [amsa_pkg::SQ_W-1:0]    sq_mem  [ATTRIBUTES];
   logic [ATTRIBUTES-1:0]        valid_ff;
   logic [amsa_pkg::SUM_W-1:0]   rd_sum_ff;
   logic [amsa_pkg::SQ_W-1:0]    rd_sq_ff;
   logic                         rd_valid_ff;

   logic                         in_range;
   logic                         mem_we;
   logic [23:0]                  mul_a, mul_b;
   logic [47:0]                  product;
   logic [amsa_pkg::ACC_W-1:0]   acc_add;
   logic [amsa_pkg::SUM_W-1:0]   cur_sum, v_ext, new_sum;
   logic [amsa_pkg::SQ_W-1:0]    cur_sq, sq_ext, new_sq;
   logic [amsa_pkg::OPND_W-1:0]  term_diff;
   logic [amsa_pkg::SUM_W-1:0]   quot;
   logic                         unit_done;
   logic [amsa_pkg::OPND_W-1:0]  unit_result;
   logic [amsa_pkg::OPND_W-1:0]  unit_operand;
   amsa_pkg::unit_cmd_type       unit_cmd;

   assign req_ready = (state_ff == ST_IDLE);
   assign in_range  = (32'(req_data.attr_index) < ATTRIBUTES);

   // Shared multiplier: the square of the value, then three partial products
   // of the absolute sum split into a high 16-bit and a low 24-bit part.
   always_comb begin
      mul_a = abs_v_ff;
      mul_b = abs_v_ff;
      if (state_ff == ST_MUL) begin
         unique case (mcnt_ff)
            2'd0: begin
               mul_a = abs_sum_ff[23:0];
               mul_b = abs_sum_ff[23:0];
            end
            2'd1: begin
               mul_a = {8'b0, abs_sum_ff[39:24]};
               mul_b = abs_sum_ff[23:0];
            end
            default: begin
               mul_a = {8'b0, abs_sum_ff[39:24]};
               mul_b = {8'b0, abs_sum_ff[39:24]};
            end
         endcase
      end
   end

   assign product = mul_a * mul_b;

   // Weight of the product registered in the previous step.
   always_comb begin
      unique case (mcnt_ff)
         2'd1:    acc_add = amsa_pkg::ACC_W'(prod_ff);
         2'd2:    acc_add = amsa_pkg::ACC_W'(prod_ff) << 25;
         2'd3:    acc_add = amsa_pkg::ACC_W'(prod_ff) << 48;
         default: acc_add = '0;
      endcase
   end

   // Read-modify-write of the addressed entry; an entry never written reads as zero.
   assign cur_sum = rd_valid_ff ? rd_sum_ff : '0;
   assign cur_sq  = rd_valid_ff ? rd_sq_ff : '0;
   assign v_ext   = {{(amsa_pkg::SUM_W-24){value_ff[23]}}, value_ff};
   assign sq_ext  = amsa_pkg::SQ_W'(prod_ff[47:16]);

   always_comb begin
      unique case (op_ff)
         amsa_pkg::OP_ADD: begin
            new_sum = cur_sum + v_ext;
            new_sq  = cur_sq + sq_ext;
            mem_we  = (state_ff == ST_UPDATE);
         end
         amsa_pkg::OP_REMOVE: begin
            new_sum = cur_sum - v_ext;
            new_sq  = cur_sq - sq_ext;
            mem_we  = (state_ff == ST_UPDATE);
         end
         default: begin
            new_sum = cur_sum;
            new_sq  = cur_sq;
            mem_we  = 1'b0;
         end
      endcase
   end

   // Sum of squares less the squared-sum term, as a signed 64-bit value.
   assign term_diff = {{(amsa_pkg::OPND_W-amsa_pkg::SQ_W){sumsq_ff[amsa_pkg::SQ_W-1]}}, sumsq_ff}
                      - unit_result;
   assign quot      = unit_result[amsa_pkg::SUM_W-1:0];

   // Command and left-aligned operand for the shared unit in each pass.
   always_comb begin
      unit_cmd.start   = 1'b0;
      unit_cmd.is_sqrt = 1'b0;
      unit_cmd.steps   = amsa_pkg::MEAN_STEPS;
      unit_cmd.divisor = count_ff;
      unit_operand     = {abs_sum_ff, 24'b0};
      unique case (state_ff)
         ST_MEAN: begin
            unit_cmd.start = ~launched_ff && (count_ff != '0);
         end
         ST_TERM: begin
            unit_cmd.start = ~launched_ff;
            unit_cmd.steps = amsa_pkg::TERM_STEPS;
            unit_operand   = {acc_ff[amsa_pkg::ACC_W-1:16], 1'b0};
         end
         ST_VAR: begin
            unit_cmd.start   = ~launched_ff;
            unit_cmd.steps   = amsa_pkg::VAR_STEPS;
            unit_cmd.divisor = count_ff - 1'b1;
            unit_operand     = {work_ff, 17'b0};
         end
         ST_ROOT: begin
            unit_cmd.start   = ~launched_ff;
            unit_cmd.is_sqrt = 1'b1;
            unit_cmd.steps   = amsa_pkg::ROOT_STEPS;
            unit_operand     = {1'b0, work_ff, 16'b0};
         end
         default: begin
            unit_cmd.start = 1'b0;
         end
      endcase
   end

   amsa_unit u_amsa_unit (
      .clock   (clock),
      .reset   (reset),
      .cmd     (unit_cmd),
      .operand (unit_operand),
      .done    (unit_done),
      .result  (unit_result)
   );

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      echo_in      = echo_ff;
      idx_in       = idx_ff;
      value_in     = value_ff;
      abs_v_in     = abs_v_ff;
      count_in     = count_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      sumsq_in     = sumsq_ff;
      abs_sum_in   = abs_sum_ff;
      acc_in       = acc_ff;
      mcnt_in      = mcnt_ff;
      launched_in  = launched_ff | unit_cmd.start;
      work_in      = work_ff;
      mean_in      = mean_ff;
      std_in       = std_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in       = req_data.op;
               echo_in     = req_data.attr_index;
               idx_in      = IDX_W'(req_data.attr_index);
               value_in    = req_data.value;
               abs_v_in    = req_data.value[23] ? -req_data.value : req_data.value;
               count_in    = req_data.sample_count;
               mean_in     = '0;
               std_in      = '0;
               launched_in = 1'b0;
               state_in    = in_range ? ST_READ : ST_RESULT;
            end
         end
         ST_READ: begin
            prod_in  = product;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            sum_in   = new_sum;
            sumsq_in = new_sq;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            abs_sum_in = sum_ff[amsa_pkg::SUM_W-1] ? -sum_ff : sum_ff;
            acc_in     = '0;
            mcnt_in    = '0;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            prod_in = product;
            acc_in  = acc_ff + acc_add;
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == 2'd3) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (count_ff == '0) begin
               state_in = ST_RESULT;
            end else if (launched_ff && unit_done) begin
               launched_in = 1'b0;
               // Truncate toward zero, then saturate to the Q8.16 range.
               if (sum_ff[amsa_pkg::SUM_W-1]) begin
                  mean_in = (quot[amsa_pkg::SUM_W-1:23] != '0) ? amsa_pkg::MEAN_MIN
                                                               : -quot[23:0];
               end else begin
                  mean_in = (quot[amsa_pkg::SUM_W-1:23] != '0) ? amsa_pkg::MEAN_MAX
                                                               : quot[23:0];
               end
               state_in = (count_ff > 16'd1) ? ST_TERM : ST_RESULT;
            end
         end
         ST_TERM: begin
            if (launched_ff && unit_done) begin
               launched_in = 1'b0;
               // A variance that is not positive leaves the deviation at zero.
               if (!term_diff[amsa_pkg::OPND_W-1] && (term_diff != '0)) begin
                  work_in  = term_diff[46:0];
                  state_in = ST_VAR;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_VAR: begin
            if (launched_ff && unit_done) begin
               launched_in = 1'b0;
               work_in     = unit_result[46:0];
               state_in    = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (launched_ff && unit_done) begin
               launched_in = 1'b0;
               std_in      = (unit_result[amsa_pkg::ROOT_W-1:23] != '0) ? amsa_pkg::STD_MAX
                                                                      : unit_result[22:0];
               state_in    = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.echo_index = echo_ff;
               rsp_in.mean       = mean_ff;
               rsp_in.std_dev    = std_ff;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Valid bits of the store entries; reset marks every entry as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[idx_ff] <= 1'b1;
      end
   end

   // Attribute stores: written in the update step, read in the read step.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[idx_ff] <= new_sum;
         sq_mem[idx_ff]  <= new_sq;
      end
      if (state_ff == ST_READ) begin
         rd_sum_ff   <= sum_mem[idx_ff];
         rd_sq_ff    <= sq_mem[idx_ff];
         rd_valid_ff <= valid_ff[idx_ff];
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      echo_ff    <= echo_in;
      idx_ff     <= idx_in;
      value_ff   <= value_in;
      abs_v_ff   <= abs_v_in;
      count_ff   <= count_in;
      prod_ff    <= prod_in;
      sum_ff     <= sum_in;
      sumsq_ff   <= sumsq_in;
      abs_sum_ff <= abs_sum_in;
      acc_ff     <= acc_in;
      mcnt_ff    <= mcnt_in;
      work_ff    <= work_in;
      mean_ff    <= mean_in;
      std_ff     <= std_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> sv/amsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amsa_checker: port-level checks of the attribute statistics block
// Watches the request and response channels of the top level and flags
// behaviour that the one-item-at-a-time sequencer never shows.
// ----------------------------------------------------------------------------

module amsa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input amsa_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input amsa_pkg::rsp_type rsp_data
);

   // In the cycle after a request transfer the block is busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while the previous item was still in work");

   // A new result appears only as the sequencer returns to idle.
   a_result_then_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result presented while the block is not idle");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result dropped or changed");

   // Reset leaves the block idle with no result pending.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("block not idle after reset");

endmodule

bind attribute_mean_stddev_accumulator_top amsa_checker u_amsa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
